[hdl/upng_pkg.sv]
// ----------------------------------------------------------------------------
// Uncompressed PNG encoder package
// Shared types, codes, constants and the CRC-32 helper functions.
// ----------------------------------------------------------------------------
package upng_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int WIDTH_BITS  = 15;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [16:0] ADLER_MOD = 17'd65521;

   typedef struct packed {
      logic       operation;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       image_done;
   } rsp_type;

   typedef struct packed {
      logic                   is_start;
      logic                   row_start;
      logic                   final_row;
      logic                   trailer;
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [7:0]             red;
      logic [7:0]             green;
      logic [7:0]             blue;
   } cmd_type;

   function automatic logic [31:0] crc_nibble(input logic [3:0] idx);
      logic [31:0] v;
      case (idx)
         4'h0: v = 32'h00000000;
         4'h1: v = 32'h1db71064;
         4'h2: v = 32'h3b6e20c8;
         4'h3: v = 32'h26d930ac;
         4'h4: v = 32'h76dc4190;
         4'h5: v = 32'h6b6b51f4;
         4'h6: v = 32'h4db26158;
         4'h7: v = 32'h5005713c;
         4'h8: v = 32'hedb88320;
         4'h9: v = 32'hf00f9344;
         4'ha: v = 32'hd6d6a3e8;
         4'hb: v = 32'hcb61b38c;
         4'hc: v = 32'h9b64c2b0;
         4'hd: v = 32'h86d3d2d4;
         4'he: v = 32'ha00ae278;
         4'hf: v = 32'hbdbdf21c;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc;
      c = crc_nibble(c[3:0] ^ b[3:0]) ^ (c >> 4);
      c = crc_nibble(c[3:0] ^ b[7:4]) ^ (c >> 4);
      return c;
   endfunction

endpackage

[hdl/uncompressed_png_stream_encoder.sv]
// ----------------------------------------------------------------------------
// Uncompressed PNG stream encoder
// Turns start and RGB pixel transfers into the bytes of a stored-deflate PNG.
// ----------------------------------------------------------------------------
// An item's first byte passes the command queue, the byte engine's command
// register and the output register. Throughput: one output byte a cycle unless
// rsp_ready stalls it; a pixel gives 3 bytes, 9 at a row start and 20 more on
// the last pixel; a start gives 43. Reset is synchronous; it clears the image
// state, queue and output register, and sets both image dimensions to one.
module uncompressed_png_stream_encoder #(
   parameter int QueueDepth = upng_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  upng_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output upng_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [upng_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [upng_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [upng_pkg::WIDTH_BITS-1:0]  image_width_ff;
   logic [upng_pkg::HEIGHT_BITS-1:0] image_height_ff;

   logic              queue_full, push, pop, pop_valid;
   upng_pkg::cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= upng_pkg::WIDTH_BITS'(1);
         image_height_ff <= upng_pkg::HEIGHT_BITS'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            upng_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[upng_pkg::WIDTH_BITS-1:0];
            upng_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   upng_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   upng_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   upng_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/upng_queue.sv]
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out store between the classifier and the byte engine.
// ----------------------------------------------------------------------------
module upng_queue #(
   parameter int Depth = upng_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  upng_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output upng_pkg::cmd_type pop_cmd
);

   localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   upng_pkg::cmd_type mem [Depth];

   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CountBits'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(Depth))
      else $error("Queue fill count exceeds its depth.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("Command pushed into a full queue.");

endmodule

[hdl/upng_front.sv]
// ----------------------------------------------------------------------------
// Item classifier
// Accepts input transfers, tracks column, row and image state, and queues
// one command for each item that produces output bytes.
// ----------------------------------------------------------------------------
module upng_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  upng_pkg::req_type                   req_payload,
   input  logic [upng_pkg::WIDTH_BITS-1:0]     image_width,
   input  logic [upng_pkg::HEIGHT_BITS-1:0]    image_height,
   input  logic                                queue_full,
   output logic                                push,
   output upng_pkg::cmd_type                   push_cmd
);

   logic [upng_pkg::WIDTH_BITS-1:0]  column_ff, column_in;
   logic [upng_pkg::HEIGHT_BITS-1:0] row_ff, row_in;
   logic                             active_ff, active_in;
   logic [upng_pkg::WIDTH_BITS-1:0]  column_next;
   logic [upng_pkg::HEIGHT_BITS-1:0] row_next;
   logic                             accept, is_start, row_end;

   assign req_ready   = !queue_full;
   assign accept      = req_valid && req_ready;
   assign is_start    = (req_payload.operation == upng_pkg::OP_START);
   assign column_next = column_ff + 1'b1;
   assign row_next    = row_ff + 1'b1;
   assign row_end     = (column_next == image_width);
   assign push        = accept && (is_start || active_ff);

   always_comb begin
      push_cmd.is_start  = is_start;
      push_cmd.row_start = (column_ff == '0);
      push_cmd.final_row = (row_next == image_height);
      push_cmd.trailer   = row_end && (row_next == image_height);
      push_cmd.width     = image_width;
      push_cmd.height    = image_height;
      push_cmd.red       = req_payload.red;
      push_cmd.green     = req_payload.green;
      push_cmd.blue      = req_payload.blue;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      active_in = active_ff;
      if (accept) begin
         if (is_start) begin
            column_in = '0;
            row_in    = '0;
            active_in = 1'b1;
         end else if (active_ff) begin
            if (row_end) begin
               column_in = '0;
               row_in    = row_next;
               if (row_next == image_height) begin
                  active_in = 1'b0;
               end
            end else begin
               column_in = column_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         active_ff <= active_in;
      end
   end

   a_trailer_ends_image: assert property (@(posedge clock) disable iff (reset)
      (push && !push_cmd.is_start && push_cmd.trailer) |=> !active_ff)
      else $error("Image still active after its closing pixel.");

endmodule

[hdl/upng_back.sv]
// ----------------------------------------------------------------------------
// Byte engine
// Expands each queued command into its bytes, one a cycle unless rsp_ready
// stalls, keeps running CRC-32 and Adler-32 sums and registers each output byte.
// ----------------------------------------------------------------------------
module upng_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  upng_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output upng_pkg::rsp_type rsp_payload
);

   localparam logic [5:0] STEP_FIRST      = 6'd0;
   localparam logic [5:0] STEP_PIXEL_RED  = 6'd6;
   localparam logic [5:0] STEP_PIXEL_LAST = 6'd8;
   localparam logic [5:0] STEP_TRAIL_LAST = 6'd28;
   localparam logic [5:0] STEP_START_LAST = 6'd42;

   upng_pkg::cmd_type cmd_ff;
   upng_pkg::rsp_type rsp_ff;
   logic              busy_ff;
   logic              rsp_valid_ff;
   logic [5:0]        step_ff;
   logic [31:0]       crc_ff, crc_in;
   logic [15:0]       adler_low_ff, adler_high_ff;
   logic [31:0]       idat_len_ff;

   logic [5:0]  end_step, first_step;
   logic        out_free, advance, done_cmd;
   logic [7:0]  byte_val;
   logic [31:0] crc_out;
   logic [16:0] bpl;
   logic [16:0] row_len;
   logic        crc_restart, crc_hold, adler_data;
   logic [16:0] low_sum, high_sum;
   logic [15:0] low_new, high_new;
   logic [31:0] len_product;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = busy_ff && out_free;
   assign end_step   = cmd_ff.is_start ? STEP_START_LAST :
                       (cmd_ff.trailer ? STEP_TRAIL_LAST : STEP_PIXEL_LAST);
   assign done_cmd   = advance && (step_ff == end_step);
   assign cmd_pop    = cmd_valid && (!busy_ff || done_cmd);
   assign first_step = (cmd.is_start || cmd.row_start) ? STEP_FIRST : STEP_PIXEL_RED;
   assign crc_out    = ~crc_ff;
   assign bpl        = {2'b00, cmd_ff.width} + {1'b0, cmd_ff.width, 1'b0} + 17'd1;
   assign row_len    = bpl + 17'd5;
   assign len_product = {16'd0, cmd_ff.height} * {15'd0, row_len};

   always_comb begin
      byte_val    = 8'h00;
      crc_restart = 1'b0;
      crc_hold    = 1'b0;
      adler_data  = 1'b0;
      if (cmd_ff.is_start) begin
         case (step_ff)
            6'd0:  byte_val = 8'h89;
            6'd1:  byte_val = 8'h50;
            6'd2:  byte_val = 8'h4e;
            6'd3:  byte_val = 8'h47;
            6'd4:  byte_val = 8'h0d;
            6'd5:  byte_val = 8'h0a;
            6'd6:  byte_val = 8'h1a;
            6'd7:  byte_val = 8'h0a;
            6'd11: byte_val = 8'h0d;
            6'd12: begin
               byte_val    = 8'h49;
               crc_restart = 1'b1;
            end
            6'd13: byte_val = 8'h48;
            6'd14: byte_val = 8'h44;
            6'd15: byte_val = 8'h52;
            6'd18: byte_val = {1'b0, cmd_ff.width[14:8]};
            6'd19: byte_val = cmd_ff.width[7:0];
            6'd22: byte_val = cmd_ff.height[15:8];
            6'd23: byte_val = cmd_ff.height[7:0];
            6'd24: byte_val = 8'h08;
            6'd25: byte_val = 8'h02;
            6'd29: begin
               byte_val = crc_out[31:24];
               crc_hold = 1'b1;
            end
            6'd30: begin
               byte_val = crc_out[23:16];
               crc_hold = 1'b1;
            end
            6'd31: begin
               byte_val = crc_out[15:8];
               crc_hold = 1'b1;
            end
            6'd32: begin
               byte_val = crc_out[7:0];
               crc_hold = 1'b1;
            end
            6'd33: byte_val = idat_len_ff[31:24];
            6'd34: byte_val = idat_len_ff[23:16];
            6'd35: byte_val = idat_len_ff[15:8];
            6'd36: byte_val = idat_len_ff[7:0];
            6'd37: begin
               byte_val    = 8'h49;
               crc_restart = 1'b1;
            end
            6'd38: byte_val = 8'h44;
            6'd39: byte_val = 8'h41;
            6'd40: byte_val = 8'h54;
            6'd41: byte_val = 8'h78;
            6'd42: byte_val = 8'h01;
            default: byte_val = 8'h00;
         endcase
      end else begin
         case (step_ff)
            6'd0:  byte_val = {7'd0, cmd_ff.final_row};
            6'd1:  byte_val = bpl[7:0];
            6'd2:  byte_val = bpl[15:8];
            6'd3:  byte_val = ~bpl[7:0];
            6'd4:  byte_val = ~bpl[15:8];
            6'd5:  adler_data = 1'b1;
            6'd6: begin
               byte_val   = cmd_ff.red;
               adler_data = 1'b1;
            end
            6'd7: begin
               byte_val   = cmd_ff.green;
               adler_data = 1'b1;
            end
            6'd8: begin
               byte_val   = cmd_ff.blue;
               adler_data = 1'b1;
            end
            6'd9:  byte_val = adler_high_ff[15:8];
            6'd10: byte_val = adler_high_ff[7:0];
            6'd11: byte_val = adler_low_ff[15:8];
            6'd12: byte_val = adler_low_ff[7:0];
            6'd13: begin
               byte_val = crc_out[31:24];
               crc_hold = 1'b1;
            end
            6'd14: begin
               byte_val = crc_out[23:16];
               crc_hold = 1'b1;
            end
            6'd15: begin
               byte_val = crc_out[15:8];
               crc_hold = 1'b1;
            end
            6'd16: begin
               byte_val = crc_out[7:0];
               crc_hold = 1'b1;
            end
            6'd21: begin
               byte_val    = 8'h49;
               crc_restart = 1'b1;
            end
            6'd22: byte_val = 8'h45;
            6'd23: byte_val = 8'h4e;
            6'd24: byte_val = 8'h44;
            6'd25: begin
               byte_val = crc_out[31:24];
               crc_hold = 1'b1;
            end
            6'd26: begin
               byte_val = crc_out[23:16];
               crc_hold = 1'b1;
            end
            6'd27: begin
               byte_val = crc_out[15:8];
               crc_hold = 1'b1;
            end
            6'd28: begin
               byte_val = crc_out[7:0];
               crc_hold = 1'b1;
            end
            default: byte_val = 8'h00;
         endcase
      end
   end

   always_comb begin
      if (crc_hold) begin
         crc_in = crc_ff;
      end else begin
         crc_in = upng_pkg::crc_byte(crc_restart ? 32'hffffffff : crc_ff, byte_val);
      end
   end

   always_comb begin
      low_sum  = {1'b0, adler_low_ff} + {9'd0, byte_val};
      low_new  = (low_sum >= upng_pkg::ADLER_MOD) ? 16'(low_sum - upng_pkg::ADLER_MOD)
                                                  : low_sum[15:0];
      high_sum = {1'b0, adler_high_ff} + {1'b0, low_new};
      high_new = (high_sum >= upng_pkg::ADLER_MOD) ? 16'(high_sum - upng_pkg::ADLER_MOD)
                                                   : high_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= STEP_FIRST;
         rsp_valid_ff  <= 1'b0;
         crc_ff        <= 32'hffffffff;
         adler_low_ff  <= 16'd1;
         adler_high_ff <= 16'd0;
      end else begin
         if (cmd_pop) begin
            busy_ff <= 1'b1;
            step_ff <= first_step;
         end else if (done_cmd) begin
            busy_ff <= 1'b0;
         end else if (advance) begin
            step_ff <= step_ff + 1'b1;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            crc_ff       <= crc_in;
            if (cmd_ff.is_start) begin
               adler_low_ff  <= 16'd1;
               adler_high_ff <= 16'd0;
            end else if (adler_data) begin
               adler_low_ff  <= low_new;
               adler_high_ff <= high_new;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      idat_len_ff <= len_product + 32'd6;
      if (advance) begin
         rsp_ff.out_byte    <= byte_val;
         rsp_ff.last_of_run <= (step_ff == end_step);
         rsp_ff.image_done  <= !cmd_ff.is_start && (step_ff == STEP_TRAIL_LAST);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.image_done) |-> rsp_ff.last_of_run)
      else $error("Image end flagged on a byte that does not close its item.");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= end_step))
      else $error("Byte step ran past the end of its command.");

   a_crc_frozen: assert property (@(posedge clock) disable iff (reset)
      (advance && crc_hold) |=> $stable(crc_ff))
      else $error("CRC changed while its value was being sent.");

endmodule
